FILE: rtl/sli_pkg.sv
// Shared types and constants for the sorted list insert/remove block.
// Used by the controller, the datapath, the top level and the checker.
`timescale 1ns / 1ps

package sli_pkg;

	localparam int DEPTH = 16;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	localparam int VALUE_W    = 32;
	localparam int STATUS_W   = 2;
	localparam int POSITION_W = 4;
	localparam int COUNT_W    = 5;

	typedef enum logic {
		REQ_INSERT = 1'b0,
		REQ_REMOVE = 1'b1
	} req_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_DONE      = 2'd0,
		STAT_NOT_FOUND = 2'd1,
		STAT_FULL      = 2'd2
	} stat_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMP,
		ST_FIND,
		ST_UPD
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic compare;
		logic find;
		logic update;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic full_insert;
	} dp_status_t;

endpackage

FILE: rtl/sli_ctrl.sv
// Controller state machine for the sorted list block.
// Depends on sli_pkg for the state, command and status types.
`timescale 1ns / 1ps

module sli_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  sli_pkg::dp_status_t dp_status,
	output sli_pkg::cmd_t       cmd
);
	import sli_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.update) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		in_ready    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_CMP;
				end
			end
			ST_CMP: begin
				cmd.compare = 1'b1;
				// A full insert needs no search.
				state_d = dp_status.full_insert ? ST_UPD : ST_FIND;
			end
			ST_FIND: begin
				cmd.find = 1'b1;
				state_d  = ST_UPD;
			end
			ST_UPD: begin
				if (slot_free) begin
					cmd.update = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

FILE: rtl/sli_datapath.sv
// Datapath of the sorted list block: entry cells, compare row, position
// encoder and the result register. Depends on sli_pkg.
`timescale 1ns / 1ps

module sli_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  sli_pkg::cmd_t                 cmd,
	output sli_pkg::dp_status_t           dp_status,
	input  logic                          req_type,
	input  logic signed [31:0]            value,
	output logic [1:0]                    status,
	output logic [3:0]                    position,
	output logic [4:0]                    count,
	output logic signed [31:0]            smallest
);
	import sli_pkg::*;

	logic                      req_q;
	logic signed [VALUE_W-1:0] val_q;
	logic signed [VALUE_W-1:0] entries_q [DEPTH];
	logic [CNT_W-1:0]          count_q;
	logic [DEPTH-1:0]          hit_q;
	logic [IDX_W-1:0]          pos_q;
	logic                      found_q;

	logic [STATUS_W-1:0]       status_q;
	logic [POSITION_W-1:0]     position_q;
	logic [COUNT_W-1:0]        count_out_q;
	logic signed [VALUE_W-1:0] smallest_q;

	logic                      full;
	logic                      full_insert;
	logic [DEPTH-1:0]          hit_d;
	logic [IDX_W-1:0]          pos_d;
	logic signed [VALUE_W-1:0] new_e [DEPTH];
	logic [CNT_W-1:0]          count_d;
	logic                      apply;
	logic signed [VALUE_W-1:0] small_now;
	logic signed [VALUE_W-1:0] small_new;

	assign full        = (count_q == CNT_W'(DEPTH));
	assign full_insert = (req_q == REQ_INSERT) && full;
	assign dp_status.full_insert = full_insert;

	// Compare row: one compare per cell, only for occupied cells.
	always_comb begin
		for (int k = 0; k < DEPTH; k++) begin
			if (req_q == REQ_INSERT) begin
				hit_d[k] = (CNT_W'(k) < count_q) && (entries_q[k] >= val_q);
			end else begin
				hit_d[k] = (CNT_W'(k) < count_q) && (entries_q[k] == val_q);
			end
		end
	end

	// Position of the first hit; an insert with no hit goes to the end.
	always_comb begin
		if (req_q == REQ_INSERT) begin
			pos_d = count_q[IDX_W-1:0];
		end else begin
			pos_d = '0;
		end
		for (int k = DEPTH - 1; k >= 0; k--) begin
			if (hit_q[k]) begin
				pos_d = IDX_W'(k);
			end
		end
	end

	// Next contents of the cells after the shift.
	always_comb begin
		apply = !full_insert && ((req_q == REQ_INSERT) || found_q);
		for (int k = 0; k < DEPTH; k++) begin
			if (req_q == REQ_INSERT) begin
				if (IDX_W'(k) < pos_q) begin
					new_e[k] = entries_q[k];
				end else if (IDX_W'(k) == pos_q) begin
					new_e[k] = val_q;
				end else begin
					new_e[k] = entries_q[(k + DEPTH - 1) % DEPTH];
				end
			end else begin
				if (IDX_W'(k) < pos_q || k == DEPTH - 1) begin
					new_e[k] = entries_q[k];
				end else begin
					new_e[k] = entries_q[(k + 1) % DEPTH];
				end
			end
		end
		if (req_q == REQ_INSERT) begin
			count_d = count_q + CNT_W'(1);
		end else begin
			count_d = count_q - CNT_W'(1);
		end
		small_now = (count_q != '0) ? entries_q[0] : '0;
		small_new = (count_d != '0) ? new_e[0] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.update && apply) begin
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req_type;
			val_q <= value;
		end
		if (cmd.compare) begin
			hit_q <= hit_d;
		end
		if (cmd.find) begin
			pos_q   <= pos_d;
			found_q <= |hit_q;
		end
		if (cmd.update) begin
			if (apply) begin
				for (int k = 0; k < DEPTH; k++) begin
					entries_q[k] <= new_e[k];
				end
				status_q    <= STAT_DONE;
				position_q  <= POSITION_W'(pos_q);
				count_out_q <= COUNT_W'(count_d);
				smallest_q  <= small_new;
			end else begin
				status_q    <= full_insert ? STAT_FULL : STAT_NOT_FOUND;
				position_q  <= '0;
				count_out_q <= COUNT_W'(count_q);
				smallest_q  <= small_now;
			end
		end
	end

	assign status   = status_q;
	assign position = position_q;
	assign count    = count_out_q;
	assign smallest = smallest_q;

endmodule

FILE: rtl/sorted_list_insert_remove.sv
// Sorted list insert/remove: each request runs through the controller sequence load,
// compare row, position encode, shift; an insert into a full store skips the encode.
// Each request is finished by its shift before the next one is taken.
// A new request is taken while the previous result still waits in the output register.
// Reset (arst_n low) empties the store and drops any pending result; entry contents
// are left as they were and are only read once written.
`timescale 1ns / 1ps

module sorted_list_insert_remove (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               req_type,
	input  logic signed [31:0] value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         status,
	output logic [3:0]         position,
	output logic [4:0]         count,
	output logic signed [31:0] smallest
);
	import sli_pkg::*;

	// The controller sequences each request through the datapath. It only
	// issues the update step when the output register is free or is being
	// emptied in the same cycle, so no result is ever overwritten.
	cmd_t       cmd;
	dp_status_t dp_status;

	sli_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.dp_status (dp_status),
		.cmd       (cmd)
	);

	// The datapath holds the ordered entries as a row of cells. Each cell
	// compares itself against the request value in parallel; the first hit
	// gives the position, and every cell then takes its own value, the
	// request value, or a neighbor's value in a single shift.
	sli_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.dp_status (dp_status),
		.req_type  (req_type),
		.value     (value),
		.status    (status),
		.position  (position),
		.count     (count),
		.smallest  (smallest)
	);

endmodule

FILE: rtl/sli_checker.sv
// Port-level checker for the sorted list block, with its bind statement.
// Depends on sli_pkg for the status codes and the store depth.
`timescale 1ns / 1ps

module sli_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic [1:0]         status,
	input logic [3:0]         position,
	input logic [4:0]         count,
	input logic signed [31:0] smallest
);
	import sli_pkg::*;

	// A waiting result holds until its transfer.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(count))
	else $error("result changed while stalled");

	// A rejected request carries position zero, and a full report only comes
	// with a full store.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != STAT_DONE |->
			position == '0 && (status != STAT_FULL || count == COUNT_W'(DEPTH)))
	else $error("rejected result with a bad position or count");

	// The count never exceeds the depth, and no undefined status code appears.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> count <= COUNT_W'(DEPTH) && status != 2'd3)
	else $error("count or status out of range");

	// An empty store reports zero as its smallest value.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && count == '0 |-> smallest == '0)
	else $error("empty store with nonzero smallest");

	// A request transfer closes the input while that request is worked on.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
	else $error("input still open right after a request transfer");

endmodule

bind sorted_list_insert_remove sli_checker u_sli_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.status    (status),
	.position  (position),
	.count     (count),
	.smallest  (smallest)
);

FILE: tb/sorted_list_insert_remove_checker.sv
// Checker for the sorted list insert/remove block: watches both channels,
// keeps its own sorted store and compares every reply field by field.
// Depends on sli_pkg for the depth and the request and status codes.
`timescale 1ns / 1ps

module sorted_list_insert_remove_checker
	import sli_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic               req_type,
	input  logic signed [31:0] value,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic [1:0]         status,
	input  logic [3:0]         position,
	input  logic [4:0]         count,
	input  logic signed [31:0] smallest,
	output int                 fail_count,
	output int                 outstanding,
	output int                 n_placed,
	output int                 n_removed,
	output int                 n_full,
	output int                 n_missed
);

	typedef struct packed {
		stat_t                  st;
		logic [POSITION_W-1:0]  pos;
		logic [COUNT_W-1:0]     cnt;
		logic signed [31:0]     low;
	} reply_t;

	logic signed [31:0] sorted_vals [DEPTH];
	int                 held;
	reply_t             due_replies [$];

	// Applies one request to the local store and returns the reply it should produce.
	function automatic reply_t apply_request(req_t kind, logic signed [31:0] v);
		reply_t res;
		int     k;
		int     slot;
		bit     hit;
		res.st = STAT_DONE;
		slot = 0;
		hit = 1'b0;
		if (kind == REQ_INSERT) begin
			if (held >= DEPTH) begin
				res.st = STAT_FULL;
			end else begin
				// Entries not smaller than v form a suffix; shift it up by one.
				k = held;
				while (k > 0 && sorted_vals[k-1] >= v) begin
					sorted_vals[k] = sorted_vals[k-1];
					k--;
				end
				sorted_vals[k] = v;
				slot = k;
				held++;
			end
		end else begin
			for (k = 0; k < held; k++) begin
				if (!hit && sorted_vals[k] == v) begin
					hit = 1'b1;
					slot = k;
				end
			end
			if (!hit) begin
				res.st = STAT_NOT_FOUND;
				slot = 0;
			end else begin
				for (k = slot; k + 1 < held; k++) begin
					sorted_vals[k] = sorted_vals[k+1];
				end
				held--;
			end
		end
		res.pos = slot[POSITION_W-1:0];
		res.cnt = held[COUNT_W-1:0];
		res.low = (held > 0) ? sorted_vals[0] : 32'sd0;
		return res;
	endfunction

	function automatic int field_differs(string name, longint want, longint got);
		if (want != got) begin
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			return 1;
		end
		return 0;
	endfunction

	initial begin
		fail_count = 0;
		outstanding = 0;
		n_placed = 0;
		n_removed = 0;
		n_full = 0;
		n_missed = 0;
		held = 0;
	end

	always @(posedge clk) begin
		reply_t want;
		if (!arst_n) begin
			held = 0;
			due_replies.delete();
		end else begin
			if (in_valid && in_ready) begin
				want = apply_request(req_t'(req_type), value);
				due_replies.push_back(want);
				case (want.st)
					STAT_FULL:      n_full++;
					STAT_NOT_FOUND: n_missed++;
					default:        if (req_t'(req_type) == REQ_INSERT) n_placed++;
					                else n_removed++;
				endcase
			end
			if (out_valid && out_ready) begin
				if (due_replies.size() == 0) begin
					$display("%0t ns: reply with none expected, actual status %0d position %0d",
						$time, status, position);
					fail_count++;
				end else begin
					want = due_replies.pop_front();
					fail_count += field_differs("status", want.st, status);
					fail_count += field_differs("position", want.pos, position);
					fail_count += field_differs("count", want.cnt, count);
					fail_count += field_differs("smallest", want.low, smallest);
				end
			end
		end
		outstanding <= due_replies.size();
	end

endmodule

FILE: tb/sorted_list_insert_remove_tb.sv
// Top of the testbench for the sorted list insert/remove block: clock, reset,
// request stimulus, reply back-pressure and the verdict.
// Depends on sli_pkg, the block itself and sorted_list_insert_remove_checker.
`timescale 1ns / 1ps

module sorted_list_insert_remove_tb;
	import sli_pkg::*;

	localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;
	localparam int RANDOM_ITEMS = 1420;
	localparam int POOL_SIZE    = 8;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic               req_type;
	logic signed [31:0] value;
	logic               out_valid;
	logic               out_ready;
	logic [1:0]         status;
	logic [3:0]         position;
	logic [4:0]         count;
	logic signed [31:0] smallest;

	int fail_count;
	int outstanding;
	int n_placed;
	int n_removed;
	int n_full;
	int n_missed;

	// When set, neither side idles, so the block runs at its full rate.
	bit steady;

	// A handful of values shared by inserts and removes within one phase, so that
	// removes usually find a match and duplicates pile up in the store.
	logic signed [31:0] value_pool [POOL_SIZE];

	sorted_list_insert_remove u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.req_type  (req_type),
		.value     (value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.position  (position),
		.count     (count),
		.smallest  (smallest)
	);

	sorted_list_insert_remove_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.req_type    (req_type),
		.value       (value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.position    (position),
		.count       (count),
		.smallest    (smallest),
		.fail_count  (fail_count),
		.outstanding (outstanding),
		.n_placed    (n_placed),
		.n_removed   (n_removed),
		.n_full      (n_full),
		.n_missed    (n_missed)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Idle length for either side: mostly none, sometimes short, rarely long.
	function automatic int pick_gap();
		int r;
		if (steady) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end else if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 30);
	endfunction

	// Values weighted toward the signed extremes, zero and its neighbors, since those
	// are where an ordering bug (unsigned compare, off-by-one) would show.
	function automatic logic signed [31:0] pick_value();
		int near;
		case ($urandom_range(0, 9))
			0:       return VAL_MIN;
			1:       return VAL_MAX;
			2: begin
				near = $urandom_range(0, 8);
				return near - 4;
			end
			3:       return VAL_MIN + $urandom_range(1, 3);
			4:       return VAL_MAX - $urandom_range(1, 3);
			default: return $urandom;
		endcase
	endfunction

	// Presents one request and returns at the edge where it is transferred. Valid is
	// only lowered when a gap is wanted, so a back-to-back request keeps valid high
	// rather than dropping and raising it within the same time step.
	task automatic send_request(req_t kind, logic signed [31:0] v);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= kind;
		value    <= v;
		do @(posedge clk); while (!in_ready);
	endtask

	// Stops sending and waits until every reply owed by the block has been taken.
	task automatic drain_replies();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	// Reply side: random stalls of the ready line, alternating with bursts of ready.
	initial begin
		int stall;
		out_ready <= 1'b0;
		wait (arst_n);
		forever begin
			stall = pick_gap();
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	end

	// Request side: reset, a directed walk through the corner cases, then random phases.
	initial begin
		int   i;
		int   sent;
		int   phase;
		int   phase_len;
		int   insert_pct;
		int   pool_n;
		req_t kind;
		logic signed [31:0] v;

		steady   = 1'b0;
		arst_n   <= 1'b0;
		in_valid <= 1'b0;
		req_type <= REQ_INSERT;
		value    <= 32'sd0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A remove on an empty store has nothing to match.
		send_request(REQ_REMOVE, 32'sd0);
		// Removing the only entry empties the store; smallest must then read zero.
		send_request(REQ_INSERT, VAL_MAX);
		send_request(REQ_REMOVE, VAL_MAX);
		// Extremes in both orders, then a duplicate that must land ahead of its equal.
		send_request(REQ_INSERT, VAL_MIN);
		send_request(REQ_INSERT, VAL_MAX);
		send_request(REQ_INSERT, 32'sd0);
		send_request(REQ_INSERT, 32'sd0);
		send_request(REQ_INSERT, -32'sd1);
		// A miss on a store that is not empty, then hits at the middle and the bottom.
		send_request(REQ_REMOVE, 32'sd1);
		send_request(REQ_REMOVE, 32'sd0);
		send_request(REQ_REMOVE, VAL_MIN);
		// Alternating bit patterns; the store now holds five entries.
		send_request(REQ_INSERT, 32'sh5555_5555);
		send_request(REQ_INSERT, 32'shAAAA_AAAA);
		// Fill up to the depth, with repeated minimum values among the entries.
		for (i = 0; i < DEPTH - 5; i++) begin
			send_request(REQ_INSERT, (i % 2 == 1) ? VAL_MIN : pick_value());
		end
		// An insert into a full store is rejected and leaves the store as it was.
		send_request(REQ_INSERT, 32'sd7);
		send_request(REQ_REMOVE, VAL_MIN);
		send_request(REQ_INSERT, VAL_MAX);

		// The sender holds off here until the block has nothing left to reply.
		drain_replies();

		// Random phases. Each has its own small value pool and insert bias: insert-heavy
		// phases push the store into the full state, remove-heavy ones drain it to empty.
		sent = 0;
		phase = 0;
		while (sent < RANDOM_ITEMS) begin
			pool_n = $urandom_range(2, POOL_SIZE);
			for (i = 0; i < POOL_SIZE; i++) begin
				value_pool[i] = pick_value();
			end
			case (phase % 3)
				0:       insert_pct = 80;
				1:       insert_pct = 25;
				default: insert_pct = 50;
			endcase
			steady = (phase % 4 == 3);
			phase_len = $urandom_range(60, 180);
			for (i = 0; i < phase_len && sent < RANDOM_ITEMS; i++) begin
				kind = ($urandom_range(0, 99) < insert_pct) ? REQ_INSERT : REQ_REMOVE;
				if ($urandom_range(0, 99) < 85) begin
					v = value_pool[$urandom_range(0, pool_n - 1)];
				end else begin
					v = pick_value();
				end
				send_request(kind, v);
				sent++;
			end
			// Now and then let the block run dry between phases.
			if ($urandom_range(0, 2) == 0) begin
				drain_replies();
			end
			phase++;
		end
		steady = 1'b0;

		drain_replies();
		// Keep the clock running to catch any reply the block should not produce.
		repeat (12) @(posedge clk);

		$display("covered %0d inserts placed, %0d removes matched, %0d inserts rejected as full,",
			n_placed, n_removed, n_full);
		$display("and %0d removes without a match, over %0d random phases", n_missed, phase);
		if (fail_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	// Hard stop in case the handshake hangs.
	initial begin
		#2_000_000;
		$display("timeout with %0d replies still owed", outstanding);
		$display("end of test: mismatches");
		$finish;
	end

endmodule
